[rtl/core/lisr_pkg.sv]
// ----------------------------------------------------------------------------
// lisr_pkg
// shared types and constants of the stereo linear-interpolation resampler
// ----------------------------------------------------------------------------
package lisr_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int RATE_W    = 18;
   localparam int LIMIT_W   = 16;
   localparam int FRAC_W    = 16;
   localparam int STEP_W    = 21;
   localparam int CSR_IDX_W = 2;
   localparam int QUO_W     = RATE_W + FRAC_W;
   localparam int REM_W     = RATE_W;
   localparam int DIV_CNT_W = 6;
   localparam int BURST_W   = 5;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(QUO_W);
   localparam logic [STEP_W-1:0]    STEP_MAX  = 21'h1FFFFF;
   localparam logic [STEP_W-1:0]    STEP_ONE  = 21'h10000;
   localparam logic [BURST_W-1:0]   BURST_MAX = 5'd25;

   localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT   = 2'd2;

   typedef enum logic [1:0] {
      MODE_INTERP,
      MODE_PASS,
      MODE_SILENT
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FINISH,
      ST_MARK
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
      logic jump;
      logic finish;
      logic mark;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic cap;
      logic out_free;
      logic need_marker;
      logic step_busy;
   } status_type;

endpackage

[rtl/core/lisr_req_if.sv]
// ----------------------------------------------------------------------------
// lisr_req_if
// input frame channel: valid/ready handshake with one stereo frame
// ----------------------------------------------------------------------------
interface lisr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lisr_pkg::SAMPLE_W-1:0] left_in;
   logic signed [lisr_pkg::SAMPLE_W-1:0] right_in;
   logic                                 first_frame;
   logic                                 last_frame;

   modport source (
      output valid, left_in, right_in, first_frame, last_frame,
      input  ready
   );

   modport sink (
      input  valid, left_in, right_in, first_frame, last_frame,
      output ready
   );
endinterface

[rtl/core/lisr_rsp_if.sv]
// ----------------------------------------------------------------------------
// lisr_rsp_if
// result channel: valid/ready handshake with one output frame or marker
// ----------------------------------------------------------------------------
interface lisr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lisr_pkg::SAMPLE_W-1:0] left_out;
   logic signed [lisr_pkg::SAMPLE_W-1:0] right_out;
   logic                                 sample_valid;
   logic                                 run_done;
   logic [lisr_pkg::LIMIT_W-1:0]         frames_written;

   modport source (
      output valid, left_out, right_out, sample_valid, run_done, frames_written,
      input  ready
   );

   modport sink (
      input  valid, left_out, right_out, sample_valid, run_done, frames_written,
      output ready
   );
endinterface

[rtl/core/lisr_csr_step.sv]
// ----------------------------------------------------------------------------
// lisr_csr_step
// configuration registers and serial divider forming the q16 step and mode
// ----------------------------------------------------------------------------
module lisr_csr_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lisr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lisr_pkg::RATE_W-1:0]         csr_write_data,
   output logic [lisr_pkg::LIMIT_W-1:0]        out_limit,
   output logic [lisr_pkg::STEP_W-1:0]         step,
   output lisr_pkg::mode_type                  mode,
   output logic                                busy
);

   logic [lisr_pkg::RATE_W-1:0]    src_ff, src_in;
   logic [lisr_pkg::RATE_W-1:0]    dst_ff, dst_in;
   logic [lisr_pkg::LIMIT_W-1:0]   limit_ff, limit_in;
   logic                           start_ff, start_in;
   logic                           run_ff, run_in;
   logic [lisr_pkg::DIV_CNT_W-1:0] iter_ff, iter_in;
   logic [lisr_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [lisr_pkg::QUO_W-1:0]     dvd_ff, dvd_in;
   logic [lisr_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [lisr_pkg::STEP_W-1:0]    step_ff, step_in;
   lisr_pkg::mode_type             mode_ff, mode_in;

   logic [lisr_pkg::REM_W:0] trial;
   logic [lisr_pkg::REM_W:0] trial_diff;
   logic                     fits;

   always_comb begin
      trial      = {rem_ff, dvd_ff[lisr_pkg::QUO_W-1]};
      trial_diff = trial - {1'b0, dst_ff};
      fits       = trial >= {1'b0, dst_ff};

      src_in   = src_ff;
      dst_in   = dst_ff;
      limit_in = limit_ff;
      start_in = 1'b0;
      run_in   = run_ff;
      iter_in  = iter_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      mode_in  = mode_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            lisr_pkg::CSR_SOURCE_RATE: begin
               src_in   = csr_write_data;
               start_in = 1'b1;
            end
            lisr_pkg::CSR_TARGET_RATE: begin
               dst_in   = csr_write_data;
               start_in = 1'b1;
            end
            lisr_pkg::CSR_OUT_LIMIT: begin
               limit_in = csr_write_data[lisr_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (start_ff) begin
         run_in  = 1'b1;
         iter_in = lisr_pkg::DIV_STEPS;
         rem_in  = '0;
         dvd_in  = {src_ff, {lisr_pkg::FRAC_W{1'b0}}};
         quo_in  = '0;
      end else if (run_ff) begin
         if (iter_ff != '0) begin
            iter_in = iter_ff - 1'b1;
            rem_in  = fits ? trial_diff[lisr_pkg::REM_W-1:0] : trial[lisr_pkg::REM_W-1:0];
            dvd_in  = {dvd_ff[lisr_pkg::QUO_W-2:0], 1'b0};
            quo_in  = {quo_ff[lisr_pkg::QUO_W-2:0], fits};
         end else begin
            run_in = 1'b0;
            if (|quo_ff[lisr_pkg::QUO_W-1:lisr_pkg::STEP_W]) begin
               step_in = lisr_pkg::STEP_MAX;
            end else begin
               step_in = quo_ff[lisr_pkg::STEP_W-1:0];
            end
            if (src_ff == '0 || dst_ff == '0) begin
               mode_in = lisr_pkg::MODE_SILENT;
               step_in = '0;
            end else if (src_ff == dst_ff) begin
               mode_in = lisr_pkg::MODE_PASS;
            end else begin
               mode_in = lisr_pkg::MODE_INTERP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff   <= lisr_pkg::RATE_RESET;
         dst_ff   <= lisr_pkg::RATE_RESET;
         limit_ff <= lisr_pkg::LIMIT_RESET;
         start_ff <= 1'b0;
         run_ff   <= 1'b0;
         iter_ff  <= '0;
         step_ff  <= lisr_pkg::STEP_ONE;
         mode_ff  <= lisr_pkg::MODE_PASS;
      end else begin
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         limit_ff <= limit_in;
         start_ff <= start_in;
         run_ff   <= run_in;
         iter_ff  <= iter_in;
         step_ff  <= step_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign out_limit = limit_ff;
   assign step      = step_ff;
   assign mode      = mode_ff;
   assign busy      = start_ff | run_ff;

endmodule

[rtl/core/lisr_datapath.sv]
// ----------------------------------------------------------------------------
// lisr_datapath
// frame, position and count registers, interpolator and result register
// ----------------------------------------------------------------------------
module lisr_datapath #(
   parameter int MAX_RUN_FRAMES = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lisr_pkg::cmd_type                    cmd,
   output lisr_pkg::status_type                 status,
   input  logic [lisr_pkg::LIMIT_W-1:0]         cfg_limit,
   input  logic [lisr_pkg::STEP_W-1:0]          cfg_step,
   input  lisr_pkg::mode_type                   cfg_mode,
   input  logic                                 step_busy,
   input  logic signed [lisr_pkg::SAMPLE_W-1:0] left_in,
   input  logic signed [lisr_pkg::SAMPLE_W-1:0] right_in,
   input  logic                                 first_frame,
   input  logic                                 last_frame,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [lisr_pkg::SAMPLE_W-1:0] left_out,
   output logic signed [lisr_pkg::SAMPLE_W-1:0] right_out,
   output logic                                 sample_valid,
   output logic                                 run_done,
   output logic [lisr_pkg::LIMIT_W-1:0]         frames_written
);

   localparam int IDX_W = $clog2(MAX_RUN_FRAMES + 1);
   localparam int PI_W  = $clog2(MAX_RUN_FRAMES + 32);
   localparam int POS_W = PI_W + lisr_pkg::FRAC_W;
   localparam int SW    = lisr_pkg::SAMPLE_W;
   localparam logic [IDX_W-1:0] IDX_END = IDX_W'(MAX_RUN_FRAMES);

   logic signed [SW-1:0]           cur_left_ff, cur_left_in;
   logic signed [SW-1:0]           cur_right_ff, cur_right_in;
   logic                           last_ff, last_in;
   logic signed [SW-1:0]           prev_left_ff, prev_left_in;
   logic signed [SW-1:0]           prev_right_ff, prev_right_in;
   logic                           have_prev_ff, have_prev_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [lisr_pkg::LIMIT_W-1:0]   cnt_ff, cnt_in;
   logic [lisr_pkg::STEP_W-1:0]    step_ff, step_in;
   lisr_pkg::mode_type             mode_ff, mode_in;
   logic [lisr_pkg::BURST_W-1:0]   burst_ff, burst_in;
   logic                           out_valid_ff, out_valid_in;
   logic signed [SW-1:0]           out_left_ff, out_left_in;
   logic signed [SW-1:0]           out_right_ff, out_right_in;
   logic                           out_sample_ff, out_sample_in;
   logic                           out_done_ff, out_done_in;
   logic [lisr_pkg::LIMIT_W-1:0]   out_count_ff, out_count_in;

   logic                           in_range;
   logic [PI_W-1:0]                pos_int;
   logic [PI_W-1:0]                idx_prev;
   logic                           interp_due;
   logic                           pass_due;
   logic [POS_W-1:0]               pos_next;
   logic [lisr_pkg::LIMIT_W-1:0]   cnt_next;
   logic [lisr_pkg::BURST_W-1:0]   burst_next;
   logic                           more_due;
   logic signed [SW:0]             diff_left, diff_right;
   logic signed [lisr_pkg::FRAC_W:0] frac_s;
   logic signed [2*SW+1:0]         prod_left, prod_right;
   logic signed [SW+1:0]           sum_left, sum_right;
   logic signed [SW-1:0]           lerp_left, lerp_right;

   always_comb begin
      in_range   = idx_ff < IDX_END;
      pos_int    = pos_ff[POS_W-1:lisr_pkg::FRAC_W];
      idx_prev   = PI_W'(idx_ff) - 1'b1;
      interp_due = in_range && (mode_ff == lisr_pkg::MODE_INTERP) && (idx_ff != '0)
                   && (cnt_ff < cfg_limit) && (pos_int == idx_prev);
      pass_due   = in_range && (mode_ff == lisr_pkg::MODE_PASS) && (burst_ff == '0)
                   && (cnt_ff < cfg_limit);

      pos_next   = pos_ff + POS_W'(step_ff);
      cnt_next   = cnt_ff + 1'b1;
      burst_next = burst_ff + 1'b1;
      more_due   = (mode_ff == lisr_pkg::MODE_INTERP) && (cnt_next < cfg_limit)
                   && (pos_next[POS_W-1:lisr_pkg::FRAC_W] == idx_prev)
                   && (burst_next < lisr_pkg::BURST_MAX);

      diff_left  = (SW+1)'(cur_left_ff) - (SW+1)'(prev_left_ff);
      diff_right = (SW+1)'(cur_right_ff) - (SW+1)'(prev_right_ff);
      frac_s     = $signed({1'b0, pos_ff[lisr_pkg::FRAC_W-1:0]});
      prod_left  = diff_left * frac_s;
      prod_right = diff_right * frac_s;
      sum_left   = (SW+2)'(prev_left_ff) + prod_left[2*SW+1:lisr_pkg::FRAC_W];
      sum_right  = (SW+2)'(prev_right_ff) + prod_right[2*SW+1:lisr_pkg::FRAC_W];
      lerp_left  = sum_left[SW-1:0];
      lerp_right = sum_right[SW-1:0];

      status.emit        = (interp_due && (burst_ff < lisr_pkg::BURST_MAX)) || pass_due;
      status.cap         = interp_due && (burst_ff >= lisr_pkg::BURST_MAX);
      status.out_free    = !out_valid_ff || rsp_ready;
      status.need_marker = last_ff && (burst_ff == '0);
      status.step_busy   = step_busy;
   end

   always_comb begin
      cur_left_in   = cur_left_ff;
      cur_right_in  = cur_right_ff;
      last_in       = last_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      have_prev_in  = have_prev_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      mode_in       = mode_ff;
      burst_in      = burst_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_left_in   = out_left_ff;
      out_right_in  = out_right_ff;
      out_sample_in = out_sample_ff;
      out_done_in   = out_done_ff;
      out_count_in  = out_count_ff;

      if (cmd.load) begin
         cur_left_in  = left_in;
         cur_right_in = right_in;
         last_in      = last_frame;
         burst_in     = '0;
         if (first_frame || !have_prev_ff) begin
            pos_in       = '0;
            idx_in       = '0;
            cnt_in       = '0;
            step_in      = cfg_step;
            mode_in      = cfg_mode;
            have_prev_in = 1'b0;
         end
      end

      if (cmd.emit) begin
         cnt_in        = cnt_next;
         burst_in      = burst_next;
         out_valid_in  = 1'b1;
         out_sample_in = 1'b1;
         out_done_in   = last_ff && !more_due;
         out_count_in  = cnt_next;
         if (mode_ff == lisr_pkg::MODE_PASS) begin
            out_left_in  = cur_left_ff;
            out_right_in = cur_right_ff;
         end else begin
            out_left_in  = lerp_left;
            out_right_in = lerp_right;
            pos_in       = pos_next;
         end
      end

      if (cmd.jump) begin
         pos_in = {PI_W'(idx_ff), {lisr_pkg::FRAC_W{1'b0}}};
      end

      if (cmd.finish) begin
         if (in_range) begin
            prev_left_in  = cur_left_ff;
            prev_right_in = cur_right_ff;
            idx_in        = idx_ff + 1'b1;
         end
         have_prev_in = !last_ff;
      end

      if (cmd.mark) begin
         out_valid_in  = 1'b1;
         out_left_in   = '0;
         out_right_in  = '0;
         out_sample_in = 1'b0;
         out_done_in   = 1'b1;
         out_count_in  = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         have_prev_ff  <= 1'b0;
         pos_ff        <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         step_ff       <= lisr_pkg::STEP_ONE;
         mode_ff       <= lisr_pkg::MODE_INTERP;
         burst_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         have_prev_ff  <= have_prev_in;
         pos_ff        <= pos_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         step_ff       <= step_in;
         mode_ff       <= mode_in;
         burst_ff      <= burst_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_left_ff   <= cur_left_in;
      cur_right_ff  <= cur_right_in;
      last_ff       <= last_in;
      out_left_ff   <= out_left_in;
      out_right_ff  <= out_right_in;
      out_sample_ff <= out_sample_in;
      out_done_ff   <= out_done_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign left_out       = out_left_ff;
   assign right_out      = out_right_ff;
   assign sample_valid   = out_sample_ff;
   assign run_done       = out_done_ff;
   assign frames_written = out_count_ff;

endmodule

[rtl/core/lisr_ctrl.sv]
// ----------------------------------------------------------------------------
// lisr_ctrl
// sequencer: accepts a frame, walks its output burst, closes the frame
// ----------------------------------------------------------------------------
module lisr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lisr_pkg::status_type status,
   output lisr_pkg::cmd_type    cmd
);

   lisr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lisr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;

      unique case (state_ff)
         lisr_pkg::ST_IDLE: begin
            req_ready = !status.step_busy;
            if (req_valid && !status.step_busy) begin
               cmd.load = 1'b1;
               state_in = lisr_pkg::ST_EVAL;
            end
         end
         lisr_pkg::ST_EVAL: begin
            if (status.emit) begin
               cmd.emit = status.out_free;
            end else if (status.cap) begin
               cmd.jump = 1'b1;
               state_in = lisr_pkg::ST_FINISH;
            end else begin
               state_in = lisr_pkg::ST_FINISH;
            end
         end
         lisr_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = status.need_marker ? lisr_pkg::ST_MARK : lisr_pkg::ST_IDLE;
         end
         lisr_pkg::ST_MARK: begin
            if (status.out_free) begin
               cmd.mark = 1'b1;
               state_in = lisr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lisr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/linear_interp_stereo_resampler.sv]
// ----------------------------------------------------------------------------
// linear_interp_stereo_resampler
// stereo linear-interpolation sample rate converter with q17.16 position
// ----------------------------------------------------------------------------
// req carries one 16-bit stereo frame per transfer, with first_frame and
// last_frame marking the run; rsp carries output frames, and the final result
// of a run sets run_done (a marker-only result has sample_valid low).
// csr_* writes source_rate, target_rate and out_limit; a rate write starts a
// bit-serial divide, during which req_ready is low.
// A frame yields n outputs (at most 25), or a marker when a last frame has
// none; its first output passes the frame registers and then the result
// register; the rest follow one per cycle unless the receiver stalls.
// rsp has a result register: a new frame is taken while a result waits, and a
// stalled receiver holds the burst one output at a time.
// Reset loads 48000 Hz for both rates, an output limit of 4096 and no run.
// ----------------------------------------------------------------------------
module linear_interp_stereo_resampler #(
   parameter int MAX_RUN_FRAMES = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   lisr_req_if.sink                       req,
   lisr_rsp_if.source                     rsp,
   input  logic                           csr_write_enable,
   input  logic [lisr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lisr_pkg::RATE_W-1:0]    csr_write_data
);

   lisr_pkg::cmd_type              cmd;
   lisr_pkg::status_type           status;
   logic [lisr_pkg::LIMIT_W-1:0]   cfg_limit;
   logic [lisr_pkg::STEP_W-1:0]    cfg_step;
   lisr_pkg::mode_type             cfg_mode;
   logic                           step_busy;

   lisr_csr_step u_csr_step (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .out_limit        (cfg_limit),
      .step             (cfg_step),
      .mode             (cfg_mode),
      .busy             (step_busy)
   );

   lisr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lisr_datapath #(
      .MAX_RUN_FRAMES (MAX_RUN_FRAMES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg_limit      (cfg_limit),
      .cfg_step       (cfg_step),
      .cfg_mode       (cfg_mode),
      .step_busy      (step_busy),
      .left_in        (req.left_in),
      .right_in       (req.right_in),
      .first_frame    (req.first_frame),
      .last_frame     (req.last_frame),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .left_out       (rsp.left_out),
      .right_out      (rsp.right_out),
      .sample_valid   (rsp.sample_valid),
      .run_done       (rsp.run_done),
      .frames_written (rsp.frames_written)
   );

endmodule
